// File: src/bpa_pkg.sv
// Shared types and constants of the bitmap page allocator.
// No dependencies; every other file of the block uses it.
package bpa_pkg;

  localparam int unsigned MAX_PAGES  = 131072;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned WORDS      = MAX_PAGES / WORD_BITS;
  localparam int unsigned WIDX_W     = $clog2(WORDS);
  localparam int unsigned BIDX_W     = $clog2(WORD_BITS);
  localparam int unsigned PAGE_W     = $clog2(MAX_PAGES);
  localparam int unsigned CNT_W      = PAGE_W + 1;
  localparam int unsigned PNUM_W     = ADDR_W - PAGE_SHIFT;
  localparam int unsigned AADDR_W    = PAGE_W + PAGE_SHIFT;
  localparam int unsigned POP_W      = BIDX_W + 1;

  typedef enum logic [1:0] {
    REQ_MARK_USED = 2'd0,
    REQ_MARK_FREE = 2'd1,
    REQ_ALLOC     = 2'd2,
    REQ_FREE      = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_REJECTED = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic init_wr;
    logic load;
    logic rd;
    logic ex;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic init_last;
    logic skip;
    logic ex_done;
  } sts_t;

endpackage

// File: src/bpa_req_if.sv
// Request channel: valid/ready plus one request beat.
// Depends on bpa_pkg.
interface bpa_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       req_type;
  logic [bpa_pkg::ADDR_W-1:0]       start_addr;
  logic [bpa_pkg::ADDR_W-1:0]       end_addr;
  logic [bpa_pkg::ADDR_W-1:0]       page_addr;

  modport source (output valid, req_type, start_addr, end_addr, page_addr, input ready);
  modport sink   (input valid, req_type, start_addr, end_addr, page_addr, output ready);
endinterface

// File: src/bpa_rsp_if.sv
// Response channel: valid/ready plus one result beat.
// Depends on bpa_pkg.
interface bpa_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic [bpa_pkg::AADDR_W-1:0]      alloc_addr;
  logic [bpa_pkg::CNT_W-1:0]        free_count;

  modport source (output valid, status, alloc_addr, free_count, input ready);
  modport sink   (input valid, status, alloc_addr, free_count, output ready);
endinterface

// File: src/bpa_datapath.sv
// Bitmap memory, request decode, per-word update and free counter.
// Depends on bpa_pkg; driven by bpa_ctrl through cmd_t / sts_t.
module bpa_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bpa_pkg::cmd_t                 cmd_i,
  output bpa_pkg::sts_t                 sts_o,
  input  logic [bpa_pkg::CNT_W-1:0]     lim_i,
  input  logic [1:0]                    req_type_i,
  input  logic [bpa_pkg::ADDR_W-1:0]    start_addr_i,
  input  logic [bpa_pkg::ADDR_W-1:0]    end_addr_i,
  input  logic [bpa_pkg::ADDR_W-1:0]    page_addr_i,
  output logic [1:0]                    status_o,
  output logic [bpa_pkg::AADDR_W-1:0]   alloc_addr_o,
  output logic [bpa_pkg::CNT_W-1:0]     free_count_o
);
  import bpa_pkg::*;

  localparam int unsigned RW = PNUM_W + 1;

  logic [WORD_BITS-1:0] mem_q [WORDS];
  logic [WORD_BITS-1:0] rdata_q;

  logic [WIDX_W-1:0]  word_q;
  logic [PAGE_W-1:0]  first_q, lastm1_q;
  req_e               op_q;
  logic               skip_q;
  status_e            res_st_q;
  logic [AADDR_W-1:0] res_addr_q;
  logic [CNT_W-1:0]   free_q;
  logic [1:0]         out_st_q;
  logic [AADDR_W-1:0] out_addr_q;
  logic [CNT_W-1:0]   out_cnt_q;

  // request decode into a page range [first, last)
  logic [PNUM_W-1:0] ps, pe, pa;
  logic              so, eo, ao;
  logic [RW-1:0]     first_w, last_w, lim_w, lastc_w;
  logic              empty, reject;
  logic [PAGE_W-1:0] lastc_m1;

  always_comb begin
    ps = start_addr_i[ADDR_W-1:PAGE_SHIFT];
    pe = end_addr_i[ADDR_W-1:PAGE_SHIFT];
    pa = page_addr_i[ADDR_W-1:PAGE_SHIFT];
    so = |start_addr_i[PAGE_SHIFT-1:0];
    eo = |end_addr_i[PAGE_SHIFT-1:0];
    ao = |page_addr_i[PAGE_SHIFT-1:0];
    lim_w = RW'(lim_i);
    reject = 1'b0;
    case (req_type_i)
      REQ_MARK_USED: begin
        first_w = RW'(ps);
        last_w  = RW'(pe) + RW'(eo);
      end
      REQ_MARK_FREE: begin
        first_w = RW'(ps) + RW'(so);
        last_w  = RW'(pe);
      end
      REQ_ALLOC: begin
        first_w = '0;
        last_w  = lim_w;
      end
      default: begin
        first_w = RW'(pa);
        last_w  = RW'(pa) + RW'(1);
        reject  = ao || (RW'(pa) >= lim_w);
      end
    endcase
    lastc_w  = (last_w > lim_w) ? lim_w : last_w;
    empty    = first_w >= lastc_w;
    lastc_m1 = PAGE_W'(lastc_w - RW'(1));
  end

  // per-word update
  logic [BIDX_W-1:0]    lo, hi, bsel;
  logic [WORD_BITS-1:0] mask, chg, wnew, avail;
  logic [POP_W-1:0]     pop;
  logic                 last_word, found;
  logic [CNT_W-1:0]     free_d;

  always_comb begin
    last_word = word_q == lastm1_q[PAGE_W-1:BIDX_W];
    lo   = (word_q == first_q[PAGE_W-1:BIDX_W]) ? first_q[BIDX_W-1:0] : '0;
    hi   = last_word ? lastm1_q[BIDX_W-1:0] : '1;
    mask = ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> (BIDX_W'(WORD_BITS - 1) - hi));
    avail = ~rdata_q & mask;
    found = |avail;
    bsel  = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) bsel = BIDX_W'(i);
    end
    case (op_q)
      REQ_MARK_USED: begin
        chg  = ~rdata_q & mask;
        wnew = rdata_q | mask;
      end
      REQ_ALLOC: begin
        chg  = '0;
        wnew = rdata_q | (WORD_BITS'(1) << bsel);
      end
      default: begin
        chg  = rdata_q & mask;
        wnew = rdata_q & ~mask;
      end
    endcase
    pop = '0;
    for (int i = 0; i < WORD_BITS; i++) pop = pop + POP_W'(chg[i]);
    case (op_q)
      REQ_MARK_USED: free_d = (free_q > CNT_W'(pop)) ? free_q - CNT_W'(pop) : '0;
      REQ_ALLOC:     free_d = (found && free_q != '0) ? free_q - CNT_W'(1) : free_q;
      default: begin
        free_d = ((free_q + CNT_W'(pop)) > CNT_W'(MAX_PAGES)) ?
                 CNT_W'(MAX_PAGES) : free_q + CNT_W'(pop);
      end
    endcase
  end

  assign sts_o.init_last = word_q == WIDX_W'(WORDS - 1);
  assign sts_o.skip      = skip_q;
  assign sts_o.ex_done   = last_word || (op_q == REQ_ALLOC && found);

  // bitmap memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_wr) begin
      mem_q[word_q] <= '1;
    end else if (cmd_i.ex) begin
      mem_q[word_q] <= wnew;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[word_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      free_q <= '0;
      skip_q <= 1'b0;
      op_q   <= REQ_MARK_USED;
    end else begin
      if (cmd_i.init_wr) begin
        word_q <= word_q + WIDX_W'(1);
      end else if (cmd_i.load) begin
        word_q <= first_w[PAGE_W-1:BIDX_W];
        op_q   <= req_e'(req_type_i);
        skip_q <= empty || reject;
      end else if (cmd_i.ex) begin
        free_q <= free_d;
        if (!sts_o.ex_done) word_q <= word_q + WIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      first_q    <= first_w[PAGE_W-1:0];
      lastm1_q   <= lastc_m1;
      res_addr_q <= '0;
      if (reject) res_st_q <= ST_REJECTED;
      else if (req_type_i == REQ_ALLOC && empty) res_st_q <= ST_NO_FREE;
      else res_st_q <= ST_OK;
    end else if (cmd_i.ex && op_q == REQ_ALLOC) begin
      if (found) res_addr_q <= {word_q, bsel, {PAGE_SHIFT{1'b0}}};
      else if (last_word) res_st_q <= ST_NO_FREE;
    end
    if (cmd_i.finish) begin
      out_st_q   <= res_st_q;
      out_addr_q <= res_addr_q;
      out_cnt_q  <= free_q;
    end
  end

  assign status_o     = out_st_q;
  assign alloc_addr_o = out_addr_q;
  assign free_count_o = out_cnt_q;

endmodule

// File: src/bpa_ctrl.sv
// Sequencer: bitmap fill after reset, request accept, word walk, result hand-off.
// Depends on bpa_pkg; commands bpa_datapath.
module bpa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  input  bpa_pkg::sts_t sts_i,
  output bpa_pkg::cmd_t cmd_o
);
  import bpa_pkg::*;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_CHECK, S_RD, S_EX, S_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || rsp_ready_i;
  assign req_ready_o = state_q == S_IDLE;
  assign rsp_valid_o = out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.init_wr = state_q == S_INIT;
    cmd_o.load    = (state_q == S_IDLE) && req_valid_i;
    cmd_o.rd      = state_q == S_RD;
    cmd_o.ex      = state_q == S_EX;
    cmd_o.finish  = (state_q == S_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.finish) out_valid_q <= 1'b1;
      else if (rsp_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_INIT:  if (sts_i.init_last) state_q <= S_IDLE;
        S_IDLE:  if (req_valid_i) state_q <= S_CHECK;
        S_CHECK: state_q <= sts_i.skip ? S_DONE : S_RD;
        S_RD:    state_q <= S_EX;
        S_EX:    state_q <= sts_i.ex_done ? S_DONE : S_RD;
        S_DONE:  if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/bitmap_page_allocator.sv
// Bitmap page allocator: one used bit per page in a 2048 x 64 memory plus a
// free-page counter. After reset the block fills the bitmap with ones and takes
// no request meanwhile; page_limit writes are taken any time the block is idle.
// A request is checked, then each bitmap word visited gets a registered memory
// read and a read-modify-write: mark requests visit every word of the clipped
// range, allocate scans from word 0 until the first word with a free page,
// free-page visits one word, and rejected or empty requests visit none. The
// result beat sits in an output register.
module bitmap_page_allocator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bpa_pkg::CNT_W-1:0] cfg_wdata_i,
  bpa_req_if.sink                   req,
  bpa_rsp_if.source                 rsp
);
  import bpa_pkg::*;

  logic [CNT_W-1:0] limit_q, eff_lim;
  cmd_t             cmd;
  sts_t             sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= CNT_W'(32768);
    else if (cfg_we_i) limit_q <= cfg_wdata_i;
  end

  assign eff_lim = (limit_q > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : limit_q;

  bpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bpa_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .lim_i        (eff_lim),
    .req_type_i   (req.req_type),
    .start_addr_i (req.start_addr),
    .end_addr_i   (req.end_addr),
    .page_addr_i  (req.page_addr),
    .status_o     (rsp.status),
    .alloc_addr_o (rsp.alloc_addr),
    .free_count_o (rsp.free_count)
  );

endmodule

// File: tb/tb_top.sv
// Testbench for bitmap_page_allocator: a directed table and limit checks, then random page requests,
// all checked field by field against a behavioral copy of the page bitmap.
// Depends on bpa_pkg, bpa_req_if, bpa_rsp_if and the block itself.
`timescale 1ns / 1ps
module tb_top;
  import bpa_pkg::*;

  typedef struct packed {
    logic [1:0]        st;
    logic [AADDR_W-1:0] aaddr;
    logic [CNT_W-1:0]   cnt;
  } rsp_t;

  typedef struct {
    req_e              kind;
    logic [ADDR_W-1:0] sa;
    logic [ADDR_W-1:0] ea;
    logic [ADDR_W-1:0] pa;
    bit                known;
    rsp_t              want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;

  bpa_req_if req ();
  bpa_rsp_if rsp ();

  bitmap_page_allocator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req(req.sink), .rsp(rsp.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #20000000;
    $display("timeout at %0t", $time);
    $display("status: fail");
    $finish;
  end

  // shadow state of the allocator
  logic [WORD_BITS-1:0] page_map [WORDS];
  logic [CNT_W-1:0]     shadow_free;
  logic [CNT_W-1:0]     limit_reg;
  rsp_t                 pending_rsp [$];
  int                   errors = 0;
  int                   n_rsp = 0;
  int                   n_alloc_fail = 0;
  int                   n_reject = 0;
  bit                   rx_hold = 1'b0;

  function automatic longint unsigned active_pages();
    return (limit_reg > MAX_PAGES) ? MAX_PAGES : limit_reg;
  endfunction

  function automatic void mark_pages(longint unsigned first, longint unsigned last,
                                     bit used);
    longint unsigned p;
    if (last > active_pages()) last = active_pages();
    for (p = first; p < last; p++) begin
      if (page_map[p >> 6][p & 63] != used) begin
        page_map[p >> 6][p & 63] = used;
        if (used) begin
          if (shadow_free > 0) shadow_free--;
        end else if (shadow_free < MAX_PAGES) begin
          shadow_free++;
        end
      end
    end
  endfunction

  function automatic rsp_t apply_request(req_e kind, logic [ADDR_W-1:0] sa,
                                         logic [ADDR_W-1:0] ea, logic [ADDR_W-1:0] pa);
    rsp_t r;
    longint unsigned lim, p;
    bit found;
    r = '0;
    lim = active_pages();
    found = 1'b0;
    case (kind)
      REQ_MARK_USED: mark_pages(sa >> PAGE_SHIFT,
                                (ea >> PAGE_SHIFT) + (ea[PAGE_SHIFT-1:0] != 0), 1'b1);
      REQ_MARK_FREE: mark_pages((sa >> PAGE_SHIFT) + (sa[PAGE_SHIFT-1:0] != 0),
                                ea >> PAGE_SHIFT, 1'b0);
      REQ_ALLOC: begin
        for (p = 0; p < lim && !found; p++)
          if (!page_map[p >> 6][p & 63]) begin
            found = 1'b1;
            page_map[p >> 6][p & 63] = 1'b1;
            if (shadow_free > 0) shadow_free--;
            r.aaddr = AADDR_W'(p << PAGE_SHIFT);
          end
        if (!found) r.st = ST_NO_FREE;
      end
      default: begin
        p = pa >> PAGE_SHIFT;
        if (pa[PAGE_SHIFT-1:0] != 0 || p >= lim) begin
          r.st = ST_REJECTED;
        end else if (page_map[p >> 6][p & 63]) begin
          page_map[p >> 6][p & 63] = 1'b0;
          if (shadow_free < MAX_PAGES) shadow_free++;
        end
      end
    endcase
    r.cnt = shadow_free;
    return r;
  endfunction

  // typed expectations from the table override nothing: they must agree with the shadow
  task automatic send_request(req_e kind, logic [ADDR_W-1:0] sa, logic [ADDR_W-1:0] ea,
                              logic [ADDR_W-1:0] pa, bit known = 1'b0, rsp_t want = '0);
    rsp_t r;
    req.valid      <= 1'b1;
    req.req_type   <= kind;
    req.start_addr <= sa;
    req.end_addr   <= ea;
    req.page_addr  <= pa;
    do @(posedge clk_i); while (!req.ready);
    r = apply_request(kind, sa, ea, pa);
    if (known && r != want) begin
      $display("%0t table row mismatch: expected %h actual %h", $time, want, r);
      errors++;
    end
    pending_rsp.push_back(r);
  endtask

  task automatic idle_gap(int n);
    req.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [CNT_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_reg = v;
  endtask

  // response checker
  always @(posedge clk_i) begin
    rsp_t got, exp_r;
    if (rst_ni && rsp.valid && rsp.ready) begin
      got = '{rsp.status, rsp.alloc_addr, rsp.free_count};
      n_rsp++;
      if (pending_rsp.size() == 0) begin
        $display("%0t unexpected beat: actual %h", $time, got);
        errors++;
      end else begin
        exp_r = pending_rsp.pop_front();
        if (got.st == ST_NO_FREE) n_alloc_fail++;
        if (got.st == ST_REJECTED) n_reject++;
        if (got.st !== exp_r.st)
          $display("%0t status: expected %0d actual %0d", $time, exp_r.st, got.st);
        if (got.aaddr !== exp_r.aaddr)
          $display("%0t alloc_addr: expected %h actual %h", $time, exp_r.aaddr, got.aaddr);
        if (got.cnt !== exp_r.cnt)
          $display("%0t free_count: expected %0d actual %0d", $time, exp_r.cnt, got.cnt);
        if (got !== exp_r) errors++;
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int phase;
    rsp.ready <= 1'b0;
    phase = 0;
    forever begin
      @(posedge clk_i);
      phase++;
      if (rx_hold) begin
        rsp.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        rx_hold = 1'b0;
      end else if ((phase / 300) % 3 == 0) begin
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  function automatic logic [ADDR_W-1:0] rand_addr(int unsigned max_page);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'($urandom_range(0, max_page)) << PAGE_SHIFT;
    if ($urandom_range(0, 2) == 0) a[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
    return a;
  endfunction

  task automatic random_phase(int count, int unsigned span);
    int burst;
    req_e kind;
    logic [ADDR_W-1:0] sa, ea, pa;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        idle_gap($urandom_range(0, 6));
        burst = $urandom_range(1, 20);
      end
      burst--;
      kind = req_e'($urandom_range(0, 3));
      sa = rand_addr(span);
      ea = ($urandom_range(0, 9) == 0) ? rand_addr(span) : sa + ($urandom_range(0, 40) << 10);
      pa = rand_addr(span + 4);
      // occasional full-width noise so every address bit toggles
      if ($urandom_range(0, 30) == 0) begin
        sa = ADDR_W'({$urandom, $urandom});
        ea = ADDR_W'({$urandom, $urandom});
        pa = ADDR_W'({$urandom, $urandom});
        if (kind == REQ_MARK_USED && sa < ea && (ea - sa) > 48'h1000_0000)
          ea = sa + 48'h8000;
      end
      send_request(kind, sa, ea, pa);
    end
  endtask

  row_t dir_rows [$];

  initial begin
    localparam logic [ADDR_W-1:0] PG = 48'h1000;
    localparam logic [ADDR_W-1:0] TOP = {ADDR_W{1'b1}};
    req.valid <= 1'b0;
    req.req_type <= REQ_MARK_USED;
    req.start_addr <= '0;
    req.end_addr <= '0;
    req.page_addr <= '0;
    foreach (page_map[w]) page_map[w] = '1;
    shadow_free = 0;
    limit_reg = 32768;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_rows = '{
      '{REQ_ALLOC, 0, 0, 0, 1, '{ST_NO_FREE, 0, 0}},
      '{REQ_FREE, 0, 0, 48'h1, 1, '{ST_REJECTED, 0, 0}},
      '{REQ_FREE, 0, 0, 48'd32768 * PG, 1, '{ST_REJECTED, 0, 0}},
      '{REQ_FREE, 0, 0, TOP, 1, '{ST_REJECTED, 0, 0}},
      '{REQ_MARK_FREE, 48'h1, 48'h4FFF, 0, 1, '{ST_OK, 0, 3}},
      '{REQ_MARK_FREE, 48'h8000, 48'h8000, 0, 1, '{ST_OK, 0, 3}},
      '{REQ_MARK_FREE, 48'h9000, 48'h7000, 0, 1, '{ST_OK, 0, 3}},
      '{REQ_ALLOC, 0, 0, 0, 1, '{ST_OK, 29'h1000, 2}},
      '{REQ_FREE, 0, 0, PG, 1, '{ST_OK, 0, 3}},
      '{REQ_FREE, 0, 0, PG, 1, '{ST_OK, 0, 3}},
      '{REQ_MARK_USED, 48'h1FFF, 48'h2001, 0, 1, '{ST_OK, 0, 1}},
      '{REQ_MARK_FREE, 0, 48'd32768 * PG, 0, 1, '{ST_OK, 0, 32768}},
      '{REQ_MARK_USED, 48'd32760 * PG, TOP, 0, 1, '{ST_OK, 0, 32760}},
      '{REQ_MARK_FREE, 0, TOP, 0, 0, '{ST_OK, 0, 0}},
      '{REQ_MARK_USED, 0, 48'h1, 0, 0, '{ST_OK, 0, 0}},
      '{REQ_ALLOC, 0, 0, 0, 0, '{ST_OK, 0, 0}},
      '{REQ_MARK_USED, 0, TOP, 0, 1, '{ST_OK, 0, 0}},
      '{REQ_MARK_FREE, TOP, 0, 0, 1, '{ST_OK, 0, 0}}
    };
    foreach (dir_rows[i])
      send_request(dir_rows[i].kind, dir_rows[i].sa, dir_rows[i].ea, dir_rows[i].pa,
                   dir_rows[i].known, dir_rows[i].want);
    drain();

    // largest limit: open everything, then reject above capacity
    set_limit(CNT_W'(MAX_PAGES));
    send_request(REQ_MARK_FREE, 0, TOP, 0, 1, '{ST_OK, 0, CNT_W'(MAX_PAGES)});
    send_request(REQ_MARK_FREE, 0, TOP, 0, 1, '{ST_OK, 0, CNT_W'(MAX_PAGES)});
    send_request(REQ_FREE, 0, 0, 48'd131071 * PG, 1, '{ST_OK, 0, CNT_W'(MAX_PAGES)});
    send_request(REQ_FREE, 0, 0, 48'd131072 * PG, 1,
                 '{ST_REJECTED, 0, CNT_W'(MAX_PAGES)});
    drain();
    set_limit({CNT_W{1'b1}});  // above capacity, clamps
    send_request(REQ_MARK_USED, 48'd131000 * PG, TOP, 0);
    send_request(REQ_ALLOC, 0, 0, 0);
    drain();
    set_limit(CNT_W'(0));
    send_request(REQ_ALLOC, 0, 0, 0);
    // 72 pages marked used and one allocated out of a full bitmap
    send_request(REQ_FREE, 0, 0, 0, 1, '{ST_REJECTED, 0, 18'd130999});
    drain();

    // small limits keep scans short; long receiver hold-off fills the block
    set_limit(CNT_W'(200));
    send_request(REQ_MARK_USED, 0, TOP, 0);
    rx_hold = 1'b1;
    random_phase(600, 210);
    drain();
    set_limit(CNT_W'(64));
    random_phase(500, 80);
    drain();
    set_limit(CNT_W'(1));
    random_phase(100, 3);
    drain();
    set_limit(CNT_W'(1000));
    random_phase(600, 1010);
    drain();

    $display("covered %0d results: %0d failed allocates, %0d rejected frees, limits 0..max",
             n_rsp, n_alloc_fail, n_reject);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
src/bpa_pkg.sv
src/bpa_req_if.sv
src/bpa_rsp_if.sv
src/bpa_datapath.sv
src/bpa_ctrl.sv
src/bitmap_page_allocator.sv
tb/tb_top.sv
